>>> hw/rtl/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    // Default size of the block store and fixed field widths.
    localparam int unsigned NUM_BLOCKS_DEF = 256;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned BIT_W          = $clog2(WORD_W);
    localparam int unsigned ID_W           = 8;
    localparam int unsigned ID_SPAN        = 256;

    // Operation codes carried in the op field.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // One incoming request.
    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] blk_num;
    } t_in_req;

    // One outgoing result.
    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] granted_block;
        logic [ID_W-1:0] used_blocks;
        logic [ID_W-1:0] free_blocks;
    } t_out_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
        logic word_hit;
        logic last_word;
        logic out_free;
    } t_dp_stat;

    // Highest addressable block plus one: the 8-bit id cannot name more than 256.
    function automatic int unsigned addr_limit(input int unsigned num_blocks);
        return (num_blocks < ID_SPAN) ? num_blocks : ID_SPAN;
    endfunction

    // Map words needed to cover the addressable range, as a power-of-two index width.
    function automatic int unsigned word_idx_w(input int unsigned limit);
        int unsigned words;
        words = (limit + WORD_W - 1) / WORD_W;
        return (words > 1) ? $clog2(words) : 1;
    endfunction

    // Reset value of one map word: block 0 and blocks beyond the range read as in use.
    function automatic logic [WORD_W-1:0] map_init_word(input int unsigned widx,
                                                        input int unsigned limit);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int unsigned b = 0; b < WORD_W; b++) begin
            if ((widx * WORD_W + b == 0) || (widx * WORD_W + b >= limit)) begin
                word[b] = 1'b1;
            end
        end
        return word;
    endfunction

endpackage

>>> hw/rtl/bba_ctrl.sv
// Controller state machine for the bitmap block allocator.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_ctl_cmd o_cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Named operations go straight on; allocate walks the map words.
                if (!i_stat.is_alloc || i_stat.word_hit || i_stat.last_word) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new request is taken only when the sequencer is idle.
    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/bba_datapath.sv
// Datapath of the bitmap block allocator: free map, scan, counters and result register.
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_in_req  i_in_req,
    input  bba_pkg::t_ctl_cmd i_cmd,
    output bba_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bba_pkg::t_out_rsp o_out_rsp
);
    import bba_pkg::*;

    localparam int unsigned ADDR_LIMIT = addr_limit(NUM_BLOCKS);
    localparam int unsigned WIDX_W     = word_idx_w(ADDR_LIMIT);
    localparam int unsigned NUM_WORDS  = 2 ** WIDX_W;
    localparam logic [ID_W-1:0] FREE_TOP = ID_W'(ADDR_LIMIT - 1);

    // Map storage: one bit per block, set means in use.
    logic [WORD_W-1:0] r_map [NUM_WORDS];
    logic [ID_W-1:0]   r_used;
    logic [1:0]        r_op;
    logic [ID_W-1:0]   r_id;
    logic [WIDX_W-1:0] r_widx;
    logic              r_out_valid;
    t_out_rsp          r_out;

    logic [WIDX_W-1:0] rd_idx;
    logic [WORD_W-1:0] rd_word;
    logic              found;
    logic [BIT_W-1:0]  ffz_pos;
    logic [BIT_W-1:0]  tgt_bit;
    logic              cur_bit;
    logic              id_ok;
    logic              ok;
    logic              new_bit;
    logic [ID_W-1:0]   granted;
    logic [ID_W-1:0]   n_used;

    // One read port: the scan word for allocate, the named word otherwise.
    assign rd_idx  = (r_op == OP_ALLOC) ? r_widx : r_id[BIT_W +: WIDX_W];
    assign rd_word = r_map[rd_idx];

    // Lowest zero bit of the word being looked at.
    always_comb begin
        found   = 1'b0;
        ffz_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!rd_word[b]) begin
                found   = 1'b1;
                ffz_pos = BIT_W'(b);
            end
        end
    end

    assign id_ok   = (r_id != '0) && ({1'b0, r_id} < (ID_W + 1)'(ADDR_LIMIT));
    assign tgt_bit = (r_op == OP_ALLOC) ? ffz_pos : r_id[BIT_W-1:0];
    assign cur_bit = rd_word[tgt_bit];
    assign new_bit = (r_op != OP_RELEASE);

    // Operation decode: success and the block number reported.
    always_comb begin
        ok      = 1'b0;
        granted = '0;
        unique case (r_op)
            OP_ALLOC: begin
                ok      = found;
                granted = found ? ID_W'({r_widx, ffz_pos}) : '0;
            end
            OP_REQUEST: begin
                ok      = id_ok && !cur_bit;
                granted = r_id;
            end
            OP_RELEASE: begin
                ok      = id_ok && cur_bit;
                granted = r_id;
            end
            default: begin
                ok      = 1'b0;
                granted = '0;
            end
        endcase
    end

    // Used count after this operation.
    always_comb begin
        n_used = r_used;
        if (ok) begin
            n_used = (r_op == OP_RELEASE) ? (r_used - 1'b1) : (r_used + 1'b1);
        end
    end

    // Request capture and word counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_req.op;
            r_id   <= i_in_req.blk_num;
            r_widx <= '0;
        end else if (i_cmd.scan_step) begin
            r_widx <= r_widx + 1'b1;
        end
    end

    // Free map and used count, updated on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned w = 0; w < NUM_WORDS; w++) begin
                r_map[w] <= map_init_word(w, ADDR_LIMIT);
            end
            r_used <= '0;
        end else if (i_cmd.commit && ok) begin
            r_map[rd_idx][tgt_bit] <= new_bit;
            r_used                 <= n_used;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.ok            <= ok;
            r_out.granted_block <= granted;
            r_out.used_blocks   <= n_used;
            r_out.free_blocks   <= FREE_TOP - n_used;
        end
    end

    // Status toward the controller.
    assign o_stat.is_alloc  = (r_op == OP_ALLOC);
    assign o_stat.word_hit  = found;
    assign o_stat.last_word = (r_widx == WIDX_W'(NUM_WORDS - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

>>> hw/rtl/bitmap_block_allocator_unit.sv
// Bitmap block allocator: request and release look at the named 32-bit map word; allocate
// scans the map words in order from word 0 and stops at the first one with a free block.
// One request at a time: a new request is taken only once the sequencer is back in idle,
// after its result is written to the result register, which waits while the output stalls.
// Synchronous active-low reset marks block 0 and blocks beyond the range in use, all others free, count zero.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit #(
    parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bba_pkg::t_in_req i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output bba_pkg::t_out_rsp o_out_rsp
);
    import bba_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer.
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Map, scan and result path.
    bba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

>>> hw/rtl/bba_checker.sv
// Port-level checks for the bitmap block allocator and their bind to the top level.
`timescale 1ns / 1ps

module bba_checker #(
    parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input bba_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input bba_pkg::t_out_rsp o_out_rsp
);
    import bba_pkg::*;

    localparam logic [ID_W-1:0] FREE_TOP = ID_W'(addr_limit(NUM_BLOCKS) - 1);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed");

    // A stalled request keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_in_req))
        else $error("stalled request changed");

    // Whenever a result is valid, its used and free counts add up to the addressable user blocks.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.used_blocks + o_out_rsp.free_blocks) == FREE_TOP)
        else $error("used and free counts disagree");

    // The reserved block is never granted by a successful operation.
    a_no_block0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.ok |-> o_out_rsp.granted_block != '0)
        else $error("block 0 reported as granted");

    // One request at a time: the input stalls right after an accepted request.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted while busy");

endmodule

bind bitmap_block_allocator_unit bba_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);
